[design/tsfs_pkg.sv]
// ----------------------------------------------------------------------------
// tsfs_pkg: shared definitions of the touch sample filter and scaler
// Widths, limits, reset values and register indexes used by the top level
// and the bit-serial divider.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  // Raw sample width and scan shape.
  localparam int SAMPLE_BITS   = 12;
  localparam int SAMPLE_COUNT  = 5;
  localparam int AXIS_COUNT    = 2;
  localparam int SUM_BITS      = SAMPLE_BITS + 2;
  localparam int SORT_CNT_BITS = $clog2(SAMPLE_COUNT);

  // Divider: a dividend of two sample widths, one quotient bit per cycle.
  localparam int DIVIDEND_BITS = 2 * SAMPLE_BITS;
  localparam int DIV_CNT_BITS  = $clog2(SAMPLE_BITS + 1);

  // Register and result widths.
  localparam int SCALE_BITS     = 10;
  localparam int LIMIT_BITS     = 8;
  localparam int POS_BITS       = 10;
  localparam int PROD_BITS      = SCALE_BITS + SAMPLE_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_BITS  = ((AXIS_COUNT * SAMPLE_COUNT * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((2 * POS_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Sample acceptance window and trimmed-mean divisor.
  localparam sample_t SAMPLE_LOW_LIMIT  = sample_t'(32);
  localparam sample_t SAMPLE_HIGH_LIMIT = sample_t'(2047 - 32);
  localparam sample_t MEAN_DIVISOR      = sample_t'(3);

  // Reset values of the configuration registers and calibration bounds.
  localparam logic [SCALE_BITS-1:0] X_SCALE_RESET      = SCALE_BITS'(320);
  localparam logic [SCALE_BITS-1:0] Y_SCALE_RESET      = SCALE_BITS'(240);
  localparam logic [LIMIT_BITS-1:0] SPREAD_LIMIT_RESET = LIMIT_BITS'(32);
  localparam sample_t CAL_X_LOW_RESET  = sample_t'(150);
  localparam sample_t CAL_X_HIGH_RESET = sample_t'(1900);
  localparam sample_t CAL_Y_LOW_RESET  = sample_t'(120);
  localparam sample_t CAL_Y_HIGH_RESET = sample_t'(1900);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_X_SCALE      = 2'd0,
    CFG_Y_SCALE      = 2'd1,
    CFG_SPREAD_LIMIT = 2'd2
  } cfg_index_t;

endpackage

[design/tsfs_div.sv]
// ----------------------------------------------------------------------------
// tsfs_div: bit-serial restoring divider
// Produces one quotient bit per cycle. The upper half of the dividend must
// be below the divisor, so the quotient fits in one sample width.
// ----------------------------------------------------------------------------
module tsfs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tsfs_pkg::DIVIDEND_BITS-1:0] dividend,
  input  tsfs_pkg::sample_t                 divisor,
  output logic                              done,
  output tsfs_pkg::sample_t                 quotient
);
  import tsfs_pkg::*;

  sample_t                 rem;
  sample_t                 dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic [SAMPLE_BITS:0]    trial;
  logic                    fits;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quotient[SAMPLE_BITS-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem      <= dividend[DIVIDEND_BITS-1:SAMPLE_BITS];
      quotient <= dividend[SAMPLE_BITS-1:0];
      dvs      <= divisor;
      cnt      <= DIV_CNT_BITS'(SAMPLE_BITS);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      if (fits) begin
        rem <= sample_t'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[SAMPLE_BITS-1:0];
      end
      quotient <= {quotient[SAMPLE_BITS-2:0], fits};
      cnt      <= cnt - DIV_CNT_BITS'(1);
      if (cnt == DIV_CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[design/touch_sample_filter_scaler.sv]
// ----------------------------------------------------------------------------
// touch_sample_filter_scaler: resistive touch scan filter and scaler
// Trimmed mean of five samples per axis with spread and window checks,
// self-extending calibration and scaling to screen coordinates.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tuser pen_down, tdata samples
//  m_axis    out        m_axis_tvalid/tready      tuser pressed, tdata position
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  A pen-down scan passes twice through the bit-serial dividers: once
//  for the trimmed mean, once for the position. A release goes straight
//  to the output state. One scan is in work at a time; a result waits
//  in the output register while the next scan is accepted. Reset is
//  synchronous and restores the registers and calibration bounds;
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module touch_sample_filter_scaler (
  input  logic                                clk,
  input  logic                                rst,
  // Scan requests.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: x_sample_0..x_sample_4, y_sample_0..y_sample_4.
  input  logic [tsfs_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // tuser: pen_down.
  input  logic                                s_axis_tuser,
  // Position results.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: pos_x, pos_y, zero padding.
  output logic [tsfs_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // tuser: pressed.
  output logic                                m_axis_tuser,
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tsfs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tsfs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_CHECK,
    ST_SCALE,
    ST_MUL,
    ST_POS,
    ST_POS_WAIT,
    ST_OUT
  } state_t;

  state_t state;

  logic [SCALE_BITS-1:0] x_scale;
  logic [SCALE_BITS-1:0] y_scale;
  logic [LIMIT_BITS-1:0] spread_limit;

  sample_t cal_x_low;
  sample_t cal_x_high;
  sample_t cal_y_low;
  sample_t cal_y_high;
  logic    touch_active;
  logic [POS_BITS-1:0] last_x;
  logic [POS_BITS-1:0] last_y;
  logic    res_pressed;

  // Working registers of the scan in progress.
  sample_t vx [SAMPLE_COUNT];
  sample_t vy [SAMPLE_COUNT];
  sample_t vx_next [SAMPLE_COUNT];
  sample_t vy_next [SAMPLE_COUNT];
  logic [SORT_CNT_BITS-1:0] sort_cnt;
  sample_t mean_x;
  sample_t mean_y;
  sample_t diff_x;
  sample_t diff_y;
  sample_t span_x;
  sample_t span_y;
  logic [PROD_BITS-1:0] prod_x;
  logic [PROD_BITS-1:0] prod_y;

  logic [SUM_BITS-1:0] sum_x;
  logic [SUM_BITS-1:0] sum_y;
  logic                reject_x;
  logic                reject_y;
  sample_t             limit_ext;
  sample_t             low_x_next;
  sample_t             high_x_next;
  sample_t             low_y_next;
  sample_t             high_y_next;
  logic                out_free;

  logic                     div_start;
  logic [DIVIDEND_BITS-1:0] div_dividend_x;
  logic [DIVIDEND_BITS-1:0] div_dividend_y;
  sample_t                  div_divisor_x;
  sample_t                  div_divisor_y;
  logic                     div_done_x;
  logic                     div_done_y;
  sample_t                  div_quo_x;
  sample_t                  div_quo_y;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale      <= X_SCALE_RESET;
      y_scale      <= Y_SCALE_RESET;
      spread_limit <= SPREAD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_SCALE:      x_scale      <= cfg_data[SCALE_BITS-1:0];
        CFG_Y_SCALE:      y_scale      <= cfg_data[SCALE_BITS-1:0];
        CFG_SPREAD_LIMIT: spread_limit <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One odd-even transposition round per cycle on both axes.
  always_comb begin
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      vx_next[i] = vx[i];
      vy_next[i] = vy[i];
    end
    for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
      if (1'(i) == sort_cnt[0]) begin
        if (vx[i] > vx[i+1]) begin
          vx_next[i]   = vx[i+1];
          vx_next[i+1] = vx[i];
        end
        if (vy[i] > vy[i+1]) begin
          vy_next[i]   = vy[i+1];
          vy_next[i+1] = vy[i];
        end
      end
    end
  end

  // Sum of the middle three sorted samples.
  always_comb begin
    sum_x = SUM_BITS'(vx[1]) + SUM_BITS'(vx[2]) + SUM_BITS'(vx[3]);
    sum_y = SUM_BITS'(vy[1]) + SUM_BITS'(vy[2]) + SUM_BITS'(vy[3]);
  end

  // The extremes of a sorted axis bound both the spread and the window.
  always_comb begin
    limit_ext = sample_t'(spread_limit);
    reject_x  = (mean_x - vx[0] > limit_ext) ||
                (vx[SAMPLE_COUNT-1] - mean_x > limit_ext) ||
                (vx[0] < SAMPLE_LOW_LIMIT) ||
                (vx[SAMPLE_COUNT-1] > SAMPLE_HIGH_LIMIT);
    reject_y  = (mean_y - vy[0] > limit_ext) ||
                (vy[SAMPLE_COUNT-1] - mean_y > limit_ext) ||
                (vy[0] < SAMPLE_LOW_LIMIT) ||
                (vy[SAMPLE_COUNT-1] > SAMPLE_HIGH_LIMIT);
  end

  // Calibration bounds widened to include the new means.
  always_comb begin
    low_x_next  = (mean_x < cal_x_low)  ? mean_x : cal_x_low;
    high_x_next = (mean_x > cal_x_high) ? mean_x : cal_x_high;
    low_y_next  = (mean_y < cal_y_low)  ? mean_y : cal_y_low;
    high_y_next = (mean_y > cal_y_high) ? mean_y : cal_y_high;
  end

  // Dividers are shared between the mean and the position passes.
  always_comb begin
    div_start = (state == ST_MEAN) || (state == ST_POS);
    if (state == ST_MEAN) begin
      div_dividend_x = DIVIDEND_BITS'(sum_x);
      div_dividend_y = DIVIDEND_BITS'(sum_y);
      div_divisor_x  = MEAN_DIVISOR;
      div_divisor_y  = MEAN_DIVISOR;
    end else begin
      div_dividend_x = DIVIDEND_BITS'(prod_x);
      div_dividend_y = DIVIDEND_BITS'(prod_y);
      div_divisor_x  = span_x;
      div_divisor_y  = span_y;
    end
  end

  tsfs_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend_x),
    .divisor  (div_divisor_x),
    .done     (div_done_x),
    .quotient (div_quo_x)
  );

  tsfs_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend_y),
    .divisor  (div_divisor_y),
    .done     (div_done_y),
    .quotient (div_quo_y)
  );

  // Scan sequencer, calibration state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sort_cnt      <= '0;
      cal_x_low     <= CAL_X_LOW_RESET;
      cal_x_high    <= CAL_X_HIGH_RESET;
      cal_y_low     <= CAL_Y_LOW_RESET;
      cal_y_high    <= CAL_Y_HIGH_RESET;
      touch_active  <= 1'b0;
      last_x        <= '0;
      last_y        <= '0;
      res_pressed   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output register empties when its request is taken; in the
      // output state a new result is loaded instead.
      if (m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              for (int i = 0; i < SAMPLE_COUNT; i++) begin
                vx[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                vy[i] <= s_axis_tdata[(SAMPLE_COUNT+i)*SAMPLE_BITS +: SAMPLE_BITS];
              end
              sort_cnt <= '0;
              state    <= ST_SORT;
            end else if (touch_active) begin
              touch_active <= 1'b0;
              res_pressed  <= 1'b0;
              state        <= ST_OUT;
            end
          end
        end
        ST_SORT: begin
          for (int i = 0; i < SAMPLE_COUNT; i++) begin
            vx[i] <= vx_next[i];
            vy[i] <= vy_next[i];
          end
          sort_cnt <= sort_cnt + SORT_CNT_BITS'(1);
          if (sort_cnt == SORT_CNT_BITS'(SAMPLE_COUNT - 1)) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_done_x) begin
            mean_x <= div_quo_x;
            mean_y <= div_quo_y;
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (reject_x || reject_y) begin
            state <= ST_IDLE;
          end else begin
            cal_x_low  <= low_x_next;
            cal_x_high <= high_x_next;
            cal_y_low  <= low_y_next;
            cal_y_high <= high_y_next;
            state      <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          diff_x <= cal_x_high - mean_x;
          diff_y <= cal_y_high - mean_y;
          span_x <= cal_x_high - cal_x_low;
          span_y <= cal_y_high - cal_y_low;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod_x <= PROD_BITS'(x_scale) * PROD_BITS'(diff_x);
          prod_y <= PROD_BITS'(y_scale) * PROD_BITS'(diff_y);
          state  <= ST_POS;
        end
        ST_POS: begin
          state <= ST_POS_WAIT;
        end
        ST_POS_WAIT: begin
          if (div_done_x) begin
            // An empty calibration span scales to zero.
            last_x       <= (span_x == '0) ? '0 : div_quo_x[POS_BITS-1:0];
            last_y       <= (span_y == '0) ? '0 : div_quo_y[POS_BITS-1:0];
            touch_active <= 1'b1;
            res_pressed  <= 1'b1;
            state        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_pressed;
            m_axis_tdata  <= OUT_TDATA_BITS'({last_y, last_x});
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Both dividers always run in lockstep.
  assert property (@(posedge clk) disable iff (rst) div_done_x == div_done_y)
    else $error("axis dividers out of step");

  // Calibration bounds never narrow.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cal_x_low <= $past(cal_x_low)) && (cal_x_high >= $past(cal_x_high)) &&
                    (cal_y_low <= $past(cal_y_low)) && (cal_y_high >= $past(cal_y_high)))
    else $error("calibration bounds narrowed");

  // The calibration span stays nonempty.
  assert property (@(posedge clk) disable iff (rst)
    (cal_x_low < cal_x_high) && (cal_y_low < cal_y_high))
    else $error("empty calibration span");

  // A result leaving the sequencer lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && out_free |=> m_axis_tvalid && (state == ST_IDLE))
    else $error("result not loaded into output register");

endmodule
